// ===== sv/owbm_pkg.sv =====
`default_nettype none
package owbm_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WATCH = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_WR_FIRST  = 4'd4,
        PH_WR_SECOND = 4'd5,
        PH_RD_LOW    = 4'd6,
        PH_RD_WAIT   = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        FUNC_RESET = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_PULSE      = 3'd0,
        CFG_HALF_SLOT  = 3'd1,
        CFG_READ_WAIT  = 3'd2,
        CFG_RESET_LOW  = 3'd3,
        CFG_PRES_WIN   = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_BITS-1:0] RST_PULSE     = 16'd50;
    localparam logic [CFG_BITS-1:0] RST_HALF_SLOT = 16'd2500;
    localparam logic [CFG_BITS-1:0] RST_READ_WAIT = 16'd2500;
    localparam logic [CFG_BITS-1:0] RST_RESET_LOW = 16'd30000;
    localparam logic [CFG_BITS-1:0] RST_PRES_WIN  = 16'd5000;

    typedef struct packed {
        logic [CFG_BITS-1:0] pulse;
        logic [CFG_BITS-1:0] half_slot;
        logic [CFG_BITS-1:0] read_wait;
        logic [CFG_BITS-1:0] reset_low;
        logic [CFG_BITS-1:0] pres_win;
    } t_cfg;

    typedef struct packed {
        logic       start_req;
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       line_in;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence_ok;
    } t_res;

    // zero reads as one, wide values saturate to the timer range
    function automatic logic [TIMER_BITS-1:0] eff_len(input logic [CFG_BITS-1:0] v);
        logic [TIMER_BITS-1:0] r;
        if (v == '0) begin
            r = TIMER_BITS'(1);
        end else if (CFG_BITS > TIMER_BITS && (v >> TIMER_BITS) != '0) begin
            r = '1;
        end else begin
            r = TIMER_BITS'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/owbm_cfg.sv =====
`default_nettype none
module owbm_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [owbm_pkg::IDX_BITS-1:0] i_cfg_index,
    input  wire  [owbm_pkg::CFG_BITS-1:0] i_cfg_data,
    output owbm_pkg::t_cfg               o_cfg
);
    import owbm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PULSE:     n_cfg.pulse     = i_cfg_data;
                CFG_HALF_SLOT: n_cfg.half_slot = i_cfg_data;
                CFG_READ_WAIT: n_cfg.read_wait = i_cfg_data;
                CFG_RESET_LOW: n_cfg.reset_low = i_cfg_data;
                CFG_PRES_WIN:  n_cfg.pres_win  = i_cfg_data;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse     <= RST_PULSE;
            r_cfg.half_slot <= RST_HALF_SLOT;
            r_cfg.read_wait <= RST_READ_WAIT;
            r_cfg.reset_low <= RST_RESET_LOW;
            r_cfg.pres_win  <= RST_PRES_WIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/owbm_core.sv =====
`default_nettype none
module owbm_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_step,
    input  owbm_pkg::t_item i_item,
    input  owbm_pkg::t_cfg  i_cfg,
    output owbm_pkg::t_res  o_res
);
    import owbm_pkg::*;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [2:0]            r_bit,   n_bit;
    logic [7:0]            r_shift, n_shift;
    logic                  r_pres,  n_pres;
    logic [7:0]            r_rx,    n_rx;

    logic                  w_start;
    t_phase                w_phase;
    logic [TIMER_BITS-1:0] w_timer;
    logic [2:0]            w_bit;
    logic [7:0]            w_shift;
    logic [7:0]            w_sampled;
    logic                  w_pres;
    logic [TIMER_BITS-1:0] w_len;
    logic                  w_end;
    logic                  w_last_bit;

    // latch a new operation when idle
    always_comb begin
        w_start = (r_phase == PH_IDLE) && i_item.start_req;
        w_phase = r_phase;
        w_shift = r_shift;
        w_pres  = r_pres;
        case (i_item.func)
            FUNC_RESET: begin
                if (w_start) begin
                    w_phase = PH_RST_LOW;
                    w_pres  = 1'b0;
                end
            end
            FUNC_WRITE: begin
                if (w_start) begin
                    w_phase = PH_WR_FIRST;
                    w_shift = i_item.tx_byte;
                end
            end
            FUNC_READ: begin
                if (w_start) begin
                    w_phase = PH_RD_LOW;
                    w_shift = 8'h00;
                end
            end
            default: w_start = 1'b0;
        endcase
        w_timer    = w_start ? '0 : r_timer;
        w_bit      = w_start ? 3'd0 : r_bit;
        w_last_bit = (w_bit == 3'd7);
    end

    always_comb begin
        case (w_phase)
            PH_RST_LOW, PH_RST_REC:    w_len = eff_len(i_cfg.reset_low);
            PH_RST_WATCH:              w_len = eff_len(i_cfg.pres_win);
            PH_WR_FIRST, PH_WR_SECOND: w_len = eff_len(i_cfg.half_slot);
            PH_RD_LOW:                 w_len = eff_len(i_cfg.pulse);
            default:                   w_len = eff_len(i_cfg.read_wait);
        endcase
        w_end = ({1'b0, w_timer} + (TIMER_BITS+1)'(1)) >= {1'b0, w_len};
        w_sampled = ((w_phase == PH_RD_WAIT) && (w_timer == '0))
                  ? {i_item.line_in, w_shift[7:1]} : w_shift;
    end

    // next state
    always_comb begin
        n_phase = w_phase;
        n_timer = w_timer;
        n_bit   = w_bit;
        n_shift = w_sampled;
        n_pres  = w_pres | ((w_phase == PH_RST_WATCH) && !i_item.line_in);
        n_rx    = r_rx;
        if (w_phase != PH_IDLE) begin
            n_timer = w_end ? '0 : w_timer + TIMER_BITS'(1);
            if (w_end) begin
                case (w_phase)
                    PH_RST_LOW:   n_phase = PH_RST_WATCH;
                    PH_RST_WATCH: n_phase = PH_RST_REC;
                    PH_RST_REC:   n_phase = PH_IDLE;
                    PH_WR_FIRST:  n_phase = PH_WR_SECOND;
                    PH_WR_SECOND: begin
                        n_shift = {1'b0, w_sampled[7:1]};
                        n_phase = w_last_bit ? PH_IDLE : PH_WR_FIRST;
                        n_bit   = w_bit + 3'd1;
                    end
                    PH_RD_LOW:    n_phase = PH_RD_WAIT;
                    PH_RD_WAIT: begin
                        if (w_last_bit) begin
                            n_rx = w_sampled;
                        end
                        n_phase = w_last_bit ? PH_IDLE : PH_RD_LOW;
                        n_bit   = w_bit + 3'd1;
                    end
                    default:      n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        o_res.busy_res    = (w_phase != PH_IDLE);
        o_res.drive_low   = 1'b0;
        o_res.done_res    = 1'b0;
        o_res.rx_byte     = n_rx;
        o_res.presence_ok = n_pres;
        case (w_phase)
            PH_RST_LOW, PH_RD_LOW: o_res.drive_low = 1'b1;
            PH_WR_FIRST: o_res.drive_low = w_shift[0] ? (w_timer < eff_len(i_cfg.pulse)) : 1'b1;
            PH_RST_REC:   o_res.done_res = w_end;
            PH_WR_SECOND, PH_RD_WAIT: o_res.done_res = w_end && w_last_bit;
            default:      o_res.drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bit   <= 3'd0;
            r_shift <= 8'h00;
            r_pres  <= 1'b0;
            r_rx    <= 8'h00;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_rx    <= n_rx;
        end
    end

endmodule
`default_nettype wire

// ===== sv/one_wire_byte_master_top.sv =====
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while results are taken; a stalled result holds the input.
// Each request is one bus tick; the bus sequencer state advances once per request.
// Reset (synchronous, active low) returns the sequencer to idle, clears read and
// presence status and loads the default timing registers.
`default_nettype none
module one_wire_byte_master_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_start_req,
    input  wire  [1:0]                    i_func,
    input  wire  [7:0]                    i_tx_byte,
    input  wire                           i_line_in,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_drive_low,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [7:0]                    o_rx_byte,
    output logic                          o_presence_ok,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [owbm_pkg::IDX_BITS-1:0] i_cfg_index,
    input  wire  [owbm_pkg::CFG_BITS-1:0] i_cfg_data
);
    import owbm_pkg::*;

    t_cfg  w_cfg;
    t_res  w_res;
    t_item r_item;
    t_res  r_res;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  w_advance;

    owbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    owbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold payloads until the next request moves in
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.start_req <= i_start_req;
            r_item.func      <= i_func;
            r_item.tx_byte   <= i_tx_byte;
            r_item.line_in   <= i_line_in;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_low   = r_res.drive_low;
    assign o_busy_res    = r_res.busy_res;
    assign o_done_res    = r_res.done_res;
    assign o_rx_byte     = r_res.rx_byte;
    assign o_presence_ok = r_res.presence_ok;

endmodule
`default_nettype wire

// ===== verif/tb_one_wire_byte_master_top.sv =====
`timescale 1ns / 100ps
module tb_one_wire_byte_master_top;
    import owbm_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int N_ROWS = 33;
    localparam int N_PHASES = 5;
    localparam int TICKS_PER_PHASE = 85;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_PRINTS = 40;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [2:0] LAST_BIT = 3'd7;
    localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

    typedef enum logic [1:0] {LINE_HIGH, LINE_LOW, LINE_RAND} t_line;
    typedef enum logic {ROW_CFG, ROW_OP} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_cfg_idx            idx;
        logic [CFG_BITS-1:0] data;
        logic [1:0]          func;
        logic [7:0]          tx;
        t_line               line;
        logic                noise;
        logic                chk;
        logic [7:0]          rx;
        logic                pres;
    } t_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                start_req = 1'b0;
    logic [1:0]          func = FUNC_RESET;
    logic [7:0]          tx_byte = 8'h00;
    logic                line_in = 1'b1;
    logic                out_ready = 1'b1;
    logic                cfg_valid = 1'b0;
    t_cfg_idx            cfg_index = CFG_PULSE;
    logic [CFG_BITS-1:0] cfg_data = '0;

    wire                 o_in_ready;
    wire                 o_out_valid;
    wire                 o_drive_low;
    wire                 o_busy_res;
    wire                 o_done_res;
    wire [7:0]           o_rx_byte;
    wire                 o_presence_ok;
    wire                 o_cfg_ready;

    // bus sequencer mirror
    t_phase              seq_phase = PH_IDLE;
    int unsigned         seq_timer = 0;
    logic [2:0]          bit_idx = '0;
    logic [7:0]          shifter = '0;
    logic                pres_seen = 1'b0;
    logic [7:0]          rx_hold = '0;
    logic [CFG_BITS-1:0] cfg_now [5] = '{RST_PULSE, RST_HALF_SLOT, RST_READ_WAIT,
                                         RST_RESET_LOW, RST_PRES_WIN};

    t_res                tick_results [$];
    t_line               line_mode = LINE_HIGH;
    t_row                plan [N_ROWS];
    int                  src_pct = 10;
    int                  sink_pct = 10;
    int                  errs = 0;
    int                  n_ticks = 0;
    int                  n_results = 0;
    int                  n_cfg = 0;
    int                  ops_started = 0;
    int                  ops_done = 0;
    int                  cycle_count = 0;
    logic [7:0]          last_rx = '0;
    logic                last_pres = 1'b0;

    one_wire_byte_master_top u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_req   (start_req),
        .i_func        (func),
        .i_tx_byte     (tx_byte),
        .i_line_in     (line_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_drive_low   (o_drive_low),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_presence_ok (o_presence_ok),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned tick_len(input logic [CFG_BITS-1:0] v);
        longint unsigned top;
        longint unsigned n;
        top = (longint'(1) << TIMER_BITS) - 1;
        n = v;
        if (n == 0) begin
            n = 1;
        end else if (n > top) begin
            n = top;
        end
        return int'(n);
    endfunction

    function automatic int unsigned phase_len(input t_phase p);
        int unsigned n;
        case (p)
            PH_RST_LOW, PH_RST_REC:    n = tick_len(cfg_now[CFG_RESET_LOW]);
            PH_RST_WATCH:              n = tick_len(cfg_now[CFG_PRES_WIN]);
            PH_WR_FIRST, PH_WR_SECOND: n = tick_len(cfg_now[CFG_HALF_SLOT]);
            PH_RD_LOW:                 n = tick_len(cfg_now[CFG_PULSE]);
            default:                   n = tick_len(cfg_now[CFG_READ_WAIT]);
        endcase
        return n;
    endfunction

    function automatic t_res bus_tick(input t_item it);
        t_res r;
        logic last;
        r = '0;
        if (seq_phase == PH_IDLE && it.start_req && it.func != FUNC_NONE) begin
            seq_timer = 0;
            bit_idx = '0;
            ops_started++;
            case (it.func)
                FUNC_RESET: begin
                    pres_seen = 1'b0;
                    seq_phase = PH_RST_LOW;
                end
                FUNC_WRITE: begin
                    shifter = it.tx_byte;
                    seq_phase = PH_WR_FIRST;
                end
                default: begin
                    shifter = '0;
                    seq_phase = PH_RD_LOW;
                end
            endcase
        end
        if (seq_phase != PH_IDLE) begin
            last = (seq_timer + 1 >= phase_len(seq_phase));
            r.busy_res = 1'b1;
            case (seq_phase)
                PH_RST_LOW, PH_RD_LOW: r.drive_low = 1'b1;
                PH_RST_WATCH: begin
                    if (!it.line_in) pres_seen = 1'b1;
                end
                PH_WR_FIRST: begin
                    r.drive_low = !shifter[0] || (seq_timer < tick_len(cfg_now[CFG_PULSE]));
                end
                PH_RD_WAIT: begin
                    if (seq_timer == 0) shifter = {it.line_in, shifter[7:1]};
                end
                default: ;
            endcase
            if (last) begin
                seq_timer = 0;
                case (seq_phase)
                    PH_RST_LOW:   seq_phase = PH_RST_WATCH;
                    PH_RST_WATCH: seq_phase = PH_RST_REC;
                    PH_RST_REC: begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                    PH_WR_FIRST:  seq_phase = PH_WR_SECOND;
                    PH_WR_SECOND: begin
                        shifter = shifter >> 1;
                        if (bit_idx == LAST_BIT) begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            bit_idx++;
                            seq_phase = PH_WR_FIRST;
                        end
                    end
                    PH_RD_LOW:    seq_phase = PH_RD_WAIT;
                    default: begin
                        if (bit_idx == LAST_BIT) begin
                            rx_hold = shifter;
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            bit_idx++;
                            seq_phase = PH_RD_LOW;
                        end
                    end
                endcase
            end else begin
                seq_timer++;
            end
        end
        if (r.done_res) ops_done++;
        r.rx_byte = rx_hold;
        r.presence_ok = pres_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        errs++;
        if (errs <= MAX_PRINTS) begin
            $display("[%0t] mismatch %s at result %0d: want %0h got %0h",
                     $time, what, n_results, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) report_mismatch(what, want, got);
    endtask

    function automatic t_item make_tick(input logic s, input logic [1:0] f,
                                        input logic [7:0] tx);
        t_item it;
        it.start_req = s;
        it.func = f;
        it.tx_byte = tx;
        case (line_mode)
            LINE_HIGH: it.line_in = 1'b1;
            LINE_LOW:  it.line_in = 1'b0;
            default:   it.line_in = 1'($urandom_range(0, 1));
        endcase
        return it;
    endfunction

    function automatic t_row cfg_row(input t_cfg_idx idx, input logic [CFG_BITS-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row op_row(input logic [1:0] f, input logic [7:0] tx,
                                    input t_line line, input logic noise,
                                    input logic chk, input logic [7:0] rx,
                                    input logic pres);
        t_row r;
        r = '0;
        r.kind = ROW_OP;
        r.func = f;
        r.tx = tx;
        r.line = line;
        r.noise = noise;
        r.chk = chk;
        r.rx = rx;
        r.pres = pres;
        return r;
    endfunction

    task automatic send_tick(input t_item it);
        if (src_pct != 0 && $urandom_range(1, 100) <= src_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= it.start_req;
        func <= it.func;
        tx_byte <= it.tx_byte;
        line_in <= it.line_in;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        tick_results.push_back(bus_tick(it));
        n_ticks++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (tick_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] val);
        drain();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_now[idx] = val;
        n_cfg++;
    endtask

    // request, then hold the bus ticks coming until the sequencer is idle again
    task automatic run_op(input logic [1:0] f, input logic [7:0] tx, input logic noise);
        send_tick(make_tick(1'b1, f, tx));
        while (seq_phase != PH_IDLE) begin
            send_tick(make_tick(noise & 1'($urandom_range(0, 1)),
                                2'($urandom_range(0, 3)), 8'($urandom)));
        end
    endtask

    function automatic logic [CFG_BITS-1:0] pick_len();
        int roll;
        logic [CFG_BITS-1:0] v;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            v = '0;
        end else if (roll < 8) begin
            v = CFG_BITS'($urandom_range(1, 4));
        end else begin
            v = CFG_BITS'($urandom_range(5, 12));
        end
        return v;
    endfunction

    initial begin
        forever begin
            @(posedge clk);
            if (sink_pct != 0 && $urandom_range(1, 100) <= sink_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_res want;
        if (rst_n && o_out_valid && out_ready) begin
            if (tick_results.size() == 0) begin
                report_mismatch("result with nothing pending", 0, o_busy_res);
            end else begin
                want = tick_results[0];
                check_field("drive_low", want.drive_low, o_drive_low);
                check_field("busy", want.busy_res, o_busy_res);
                check_field("done", want.done_res, o_done_res);
                check_field("rx_byte", want.rx_byte, o_rx_byte);
                check_field("presence", want.presence_ok, o_presence_ok);
                last_rx = o_rx_byte;
                last_pres = o_presence_ok;
                n_results++;
                void'(tick_results.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, tick_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int src_mix [N_PHASES];
        int sink_mix [N_PHASES];
        int target;
        logic [1:0] f;
        src_mix = '{20, 0, 10, 35, 0};
        sink_mix = '{20, 0, 35, 10, 0};
        plan = '{
            op_row(FUNC_NONE, 8'h00, LINE_HIGH, 1'b0, 1'b1, 8'h00, 1'b0),
            cfg_row(CFG_PULSE, 16'd2),
            cfg_row(CFG_HALF_SLOT, 16'd4),
            cfg_row(CFG_READ_WAIT, 16'd3),
            cfg_row(CFG_RESET_LOW, 16'd3),
            cfg_row(CFG_PRES_WIN, 16'd4),
            op_row(FUNC_RESET, 8'h00, LINE_HIGH, 1'b0, 1'b1, 8'h00, 1'b0),
            op_row(FUNC_RESET, 8'h00, LINE_LOW, 1'b0, 1'b1, 8'h00, 1'b1),
            op_row(FUNC_WRITE, 8'h00, LINE_RAND, 1'b1, 1'b1, 8'h00, 1'b1),
            op_row(FUNC_WRITE, 8'hFF, LINE_RAND, 1'b0, 1'b0, 8'h00, 1'b0),
            op_row(FUNC_READ, 8'h00, LINE_LOW, 1'b0, 1'b1, 8'h00, 1'b1),
            op_row(FUNC_READ, 8'h00, LINE_HIGH, 1'b1, 1'b1, 8'hFF, 1'b1),
            op_row(FUNC_WRITE, 8'h5A, LINE_RAND, 1'b1, 1'b1, 8'hFF, 1'b1),
            op_row(FUNC_READ, 8'h00, LINE_RAND, 1'b1, 1'b0, 8'h00, 1'b0),
            cfg_row(CFG_PULSE, '0),
            cfg_row(CFG_HALF_SLOT, '0),
            cfg_row(CFG_READ_WAIT, '0),
            cfg_row(CFG_RESET_LOW, '0),
            cfg_row(CFG_PRES_WIN, '0),
            op_row(FUNC_WRITE, 8'hA5, LINE_RAND, 1'b1, 1'b0, 8'h00, 1'b0),
            op_row(FUNC_READ, 8'h00, LINE_HIGH, 1'b0, 1'b1, 8'hFF, 1'b1),
            op_row(FUNC_RESET, 8'h00, LINE_LOW, 1'b0, 1'b1, 8'hFF, 1'b1),
            cfg_row(CFG_PULSE, CFG_MAX),
            cfg_row(CFG_HALF_SLOT, 16'd3),
            op_row(FUNC_WRITE, 8'hFF, LINE_RAND, 1'b1, 1'b0, 8'h00, 1'b0),
            op_row(FUNC_WRITE, 8'h00, LINE_RAND, 1'b0, 1'b0, 8'h00, 1'b0),
            cfg_row(CFG_RESET_LOW, 16'd1),
            cfg_row(CFG_PRES_WIN, 16'd5),
            op_row(FUNC_RESET, 8'h00, LINE_HIGH, 1'b0, 1'b1, 8'hFF, 1'b0),
            cfg_row(CFG_HALF_SLOT, CFG_MAX),
            cfg_row(CFG_READ_WAIT, CFG_MAX),
            cfg_row(CFG_RESET_LOW, CFG_MAX),
            op_row(FUNC_NONE, 8'h3C, LINE_RAND, 1'b0, 1'b0, 8'h00, 1'b0)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                line_mode = plan[r].line;
                run_op(plan[r].func, plan[r].tx, plan[r].noise);
            end
            if (plan[r].chk) begin
                drain();
                check_field("rx_byte after directed op", plan[r].rx, last_rx);
                check_field("presence after directed op", plan[r].pres, last_pres);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            src_pct = src_mix[p];
            sink_pct = sink_mix[p];
            for (int k = 0; k < 5; k++) write_reg(t_cfg_idx'(k), pick_len());
            target = n_ticks + TICKS_PER_PHASE;
            while (n_ticks < target) begin
                repeat ($urandom_range(0, 2)) begin
                    send_tick(make_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom)));
                end
                if (p < N_PHASES - 1 && $urandom_range(0, 19) == 0) drain();
                line_mode = t_line'($urandom_range(0, 2));
                f = ($urandom_range(0, 11) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
                run_op(f, 8'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bus ticks and %0d register writes, %0d results checked",
                 n_ticks, n_cfg, n_results);
        $display("bus resets, byte writes and reads: %0d started, %0d completed",
                 ops_started, ops_done);
        if (errs == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
